FILE: hw/rtl/depth_map_checked_bilinear_remap_macros.svh
// Assertion macros shared by the remap block.
// No dependencies.
`ifndef DEPTH_MAP_CHECKED_BILINEAR_REMAP_MACROS_SVH
`define DEPTH_MAP_CHECKED_BILINEAR_REMAP_MACROS_SVH
// Implication checked on each clock edge outside reset.
`define DMR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DMR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/dmr_pkg.sv
// Package of the depth remap block: sizes, reason codes, the stage struct.
// No dependencies.
package dmr_pkg;
    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int FRAC_BITS = 8;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int BANK_COLS = MAX_COLS / 2;
    localparam int BANK_ROWS = MAX_ROWS / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int BANK_AW   = $clog2(BANK_DEPTH);
    localparam int SCALE     = 1 << FRAC_BITS;
    localparam int FW        = FRAC_BITS + 1;

    localparam logic [1:0] REASON_OK    = 2'd0;
    localparam logic [1:0] REASON_BOUNDS = 2'd1;
    localparam logic [1:0] REASON_ZERO  = 2'd2;
    localparam logic [1:0] REASON_INCONS = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Item passing from the address stage to the read stage.
    typedef struct packed {
        logic             oob;
        logic [FW-1:0]    fa;
        logic [FW-1:0]    fc;
        logic             xodd;
        logic             yodd;
    } addr_info_t;
endpackage

FILE: hw/rtl/dmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; hold read data when not enabled.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/dmr_store.sv
// Depth store split into four banks by column and row parity.
// Depends on dmr_pkg and dmr_ram.
module dmr_store (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [dmr_pkg::COL_W-1:0] wcol,
    input  logic [dmr_pkg::ROW_W-1:0] wrow,
    input  logic [15:0]               wdata,
    input  logic                      re,
    input  logic [dmr_pkg::COL_W-1:0] xl,
    input  logic [dmr_pkg::ROW_W-1:0] yl,
    input  logic [dmr_pkg::COL_W-1:0] xh,
    input  logic [dmr_pkg::ROW_W-1:0] yh,
    output logic [15:0]               bank_q [4]
);
    localparam int CH = dmr_pkg::COL_W - 1;
    localparam int RH = dmr_pkg::ROW_W - 1;

    // Bank b = {row parity, col parity}; each bank reads the neighbor of its parity.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);
        logic [CH-1:0] rc;
        logic [RH-1:0] rr;
        logic          bwe;
        assign rc  = (xl[0] == BSEL[0]) ? xl[CH:1] : xh[CH:1];
        assign rr  = (yl[0] == BSEL[1]) ? yl[RH:1] : yh[RH:1];
        assign bwe = we && (wcol[0] == BSEL[0]) && (wrow[0] == BSEL[1]);
        dmr_ram #(.WIDTH(16), .DEPTH(dmr_pkg::BANK_DEPTH)) u_ram (
            .aclk (aclk),
            .we   (bwe),
            .waddr({wrow[RH:1], wcol[CH:1]}),
            .wdata(wdata),
            .re   (re),
            .raddr({rr, rc}),
            .rdata(bank_q[b])
        );
    end
endmodule

FILE: hw/rtl/depth_map_checked_bilinear_remap.sv
// Top level of the depth remap block: address, read, check and blend stages.
// Depends on dmr_pkg, dmr_store and the macros header.
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_      | in  | pixel_col, pixel_row, depth_value, sample_x, sample_y | operation
//  m_      | out | out_depth                                           | reject_reason
//  cfg     | in  | cfg_wdata = image_cols / image_rows by cfg_index     | -
//
// One item per cycle while the output is not stalled; a sample passes six register
// stages (v1_reg to v5_reg and the output register) before m_tvalid rises.
// The pipeline advances as a whole: a stalled output freezes every stage and
// the memory reads, so nothing is lost or repeated. Writes produce no result.
// Reset clears valid bits and restores image size 640 x 480.
`include "depth_map_checked_bilinear_remap_macros.svh"
module depth_map_checked_bilinear_remap (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_col[9:0], pixel_row[19:10], depth_value[35:20], sample_x[55:36], sample_y[75:56]
    input  logic [79:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_depth[15:0]
    output logic [15:0] m_tdata,
    // reject_reason[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata
);
    localparam int FB = dmr_pkg::FRAC_BITS;
    localparam int FW = dmr_pkg::FW;
    localparam int CW = dmr_pkg::COL_W;
    localparam int RW = dmr_pkg::ROW_W;
    localparam int IW = 20 - FB + 1;

    logic [10:0] cols_reg, rows_reg;
    logic        adv;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;

    // Whole pipeline moves when the output slot is free or being drained.
    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= 11'd640;
            rows_reg <= 11'd480;
        end else if (cfg_we) begin
            if (cfg_index == dmr_pkg::REG_COLS) cols_reg <= cfg_wdata;
            else                                rows_reg <= cfg_wdata;
        end
    end

    // Stage 1: split coordinates into corners and fractions.
    logic signed [19:0] sx, sy;
    logic signed [IW-1:0] xl_s, yl_s, xh_s, yh_s;
    logic [FB-1:0] fa_w, fc_w;
    assign sx   = s_tdata[55:36];
    assign sy   = s_tdata[75:56];
    assign xl_s = IW'(sx >>> FB);
    assign yl_s = IW'(sy >>> FB);
    assign fa_w = sx[FB-1:0];
    assign fc_w = sy[FB-1:0];
    assign xh_s = xl_s + IW'(fa_w != '0);
    assign yh_s = yl_s + IW'(fc_w != '0);

    logic signed [IW-1:0] xl1_reg, yl1_reg, xh1_reg, yh1_reg;
    logic [FB-1:0] fa1_reg, fc1_reg;
    logic          smp1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
        if (adv) begin
            xl1_reg <= xl_s; yl1_reg <= yl_s; xh1_reg <= xh_s; yh1_reg <= yh_s;
            fa1_reg <= fa_w; fc1_reg <= fc_w;
            smp1_reg <= s_tuser != dmr_pkg::OP_WRITE;
        end
    end

    // Stage 2: bounds test, issue the four bank reads; writes go to the store from the input.
    logic [11:0] cols_c, rows_c;
    logic        oob;
    assign cols_c = (cols_reg < 11'(dmr_pkg::MAX_COLS)) ? {1'b0, cols_reg}
                                                         : 12'(dmr_pkg::MAX_COLS);
    assign rows_c = (rows_reg < 11'(dmr_pkg::MAX_ROWS)) ? {1'b0, rows_reg}
                                                         : 12'(dmr_pkg::MAX_ROWS);
    assign oob = xl1_reg < 0 || yl1_reg < 0 ||
                 32'(signed'(xh1_reg)) >= 32'(cols_c) ||
                 32'(signed'(yh1_reg)) >= 32'(rows_c);

    // Every write fits the store: the column and row fields span it exactly.
    logic        wr_en;
    logic [15:0] bank_q [4];
    assign wr_en = s_tvalid && adv && (s_tuser == dmr_pkg::OP_WRITE);

    dmr_store u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .wcol  (s_tdata[CW-1:0]),
        .wrow  (s_tdata[10+RW-1:10]),
        .wdata (s_tdata[35:20]),
        .re    (adv),
        .xl    (xl1_reg[CW-1:0]),
        .yl    (yl1_reg[RW-1:0]),
        .xh    (xh1_reg[CW-1:0]),
        .yh    (yh1_reg[RW-1:0]),
        .bank_q(bank_q)
    );

    dmr_pkg::addr_info_t i2_reg, i3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg && smp1_reg;
        if (adv) begin
            i2_reg.oob    <= oob;
            i2_reg.fa     <= {1'b0, fa1_reg};
            i2_reg.fc     <= {1'b0, fc1_reg};
            i2_reg.xodd   <= xl1_reg[0];
            i2_reg.yodd   <= yl1_reg[0];
        end
    end

    // Stage 3: bank data belongs to the stage-2 item; route banks to corners.
    logic [15:0] lt, rt, lb, rb;
    always_comb begin
        lt = bank_q[{i2_reg.yodd, i2_reg.xodd}];
        rt = bank_q[{i2_reg.yodd, !i2_reg.xodd}];
        lb = bank_q[{!i2_reg.yodd, i2_reg.xodd}];
        rb = bank_q[{!i2_reg.yodd, !i2_reg.xodd}];
        // Fraction zero: high corner equals low corner.
        if (i2_reg.fa == '0) begin rt = lt; rb = lb; end
        if (i2_reg.fc == '0) begin lb = lt; rb = (i2_reg.fa == '0) ? lt : rt; end
    end

    logic [15:0] lt3_reg, rt3_reg, lb3_reg, rb3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            i3_reg <= i2_reg;
            lt3_reg <= lt; rt3_reg <= rt; lb3_reg <= lb; rb3_reg <= rb;
        end
    end

    // Stage 4: average, zero test, horizontal blend products.
    logic [15:0] lt4_reg, rt4_reg, lb4_reg, rb4_reg, avg4_reg;
    logic        zero4_reg, oob4_reg;
    logic [FW-1:0] fc4_reg;
    logic [15+FW:0] top4_reg, bot4_reg;
    logic [17:0] sum4;
    assign sum4 = 18'(lt3_reg) + 18'(rt3_reg) + 18'(lb3_reg) + 18'(rb3_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            lt4_reg <= lt3_reg; rt4_reg <= rt3_reg; lb4_reg <= lb3_reg; rb4_reg <= rb3_reg;
            avg4_reg <= sum4[17:2];
            zero4_reg <= lt3_reg == '0 || rt3_reg == '0 || lb3_reg == '0 || rb3_reg == '0;
            oob4_reg <= i3_reg.oob;
            fc4_reg <= i3_reg.fc;
            top4_reg <= (16+FW)'(lt3_reg * (FW'(dmr_pkg::SCALE) - i3_reg.fa))
                      + (16+FW)'(rt3_reg * i3_reg.fa);
            bot4_reg <= (16+FW)'(lb3_reg * (FW'(dmr_pkg::SCALE) - i3_reg.fa))
                      + (16+FW)'(rb3_reg * i3_reg.fa);
        end
    end

    // Stage 5: threshold by reciprocal, deviations, vertical blend.
    logic [15:0] thr;
    logic [32:0] thr_p;
    logic [15:0] d0, d1, d2, d3;
    // Divide the average by 100; the reciprocal is exact for any 16-bit average.
    assign thr_p = 33'(avg4_reg) * 33'd83887;
    assign thr   = 16'(thr_p >> 23);
    assign d0 = lt4_reg > avg4_reg ? lt4_reg - avg4_reg : avg4_reg - lt4_reg;
    assign d1 = rt4_reg > avg4_reg ? rt4_reg - avg4_reg : avg4_reg - rt4_reg;
    assign d2 = lb4_reg > avg4_reg ? lb4_reg - avg4_reg : avg4_reg - lb4_reg;
    assign d3 = rb4_reg > avg4_reg ? rb4_reg - avg4_reg : avg4_reg - rb4_reg;

    logic [1:0]  r5_reg;
    logic [15+2*FW:0] bl5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            if (oob4_reg)       r5_reg <= dmr_pkg::REASON_BOUNDS;
            else if (zero4_reg) r5_reg <= dmr_pkg::REASON_ZERO;
            else if (d0 < thr && d1 < thr && d2 < thr && d3 < thr)
                                r5_reg <= dmr_pkg::REASON_OK;
            else                r5_reg <= dmr_pkg::REASON_INCONS;
            bl5_reg <= (16+2*FW)'(top4_reg * (FW'(dmr_pkg::SCALE) - fc4_reg))
                     + (16+2*FW)'(bot4_reg * fc4_reg);
        end
    end

    // Output register.
    logic [15:0] od_reg;
    logic [1:0]  or_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (adv) vo_reg <= v5_reg;
        if (adv) begin
            or_reg <= r5_reg;
            od_reg <= (r5_reg == dmr_pkg::REASON_OK) ? 16'(bl5_reg >> (2*FB)) : 16'd0;
        end
    end
    assign m_tvalid = vo_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = or_reg;

    `DMR_ASSERT_NXT(a_hold, aclk, aresetn, vo_reg && !m_tready, vo_reg && $stable(od_reg))
    `DMR_ASSERT_IMP(a_rej0, aclk, aresetn, vo_reg && or_reg != dmr_pkg::REASON_OK, od_reg == 16'd0)
    `DMR_ASSERT_IMP(a_nowr, aclk, aresetn, wr_en, !smp1_reg || !v1_reg || adv)
endmodule
